// ===== rtl/round_robin_task_switcher_defines.svh =====
// ----------------------------------------------------------------------------
// round robin task switcher assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SWITCHER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SWITCHER_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define RRTS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RRTS_ASSERT(lbl, prop, msg)
`define RRTS_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// shared constants, codes and types of the round robin task switcher
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW    = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW     = SlotW + 1;
  localparam int DataW    = 32;
  localparam int IdW      = 5;
  localparam int StatW    = 2;
  localparam int CmdW     = 2;
  localparam int AddrW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_EXIT   = 2'd2
  } cmd_e;

  localparam logic [StatW-1:0] STATUS_OK     = 2'd0;
  localparam logic [StatW-1:0] STATUS_FULL   = 2'd1;
  localparam logic [StatW-1:0] STATUS_REFUSE = 2'd2;

  localparam logic [AddrW-1:0] ADDR_BOOT_STACK = 2'd0;

  // write port of the slot table
  typedef struct packed {
    logic             we_sp;
    logic             we_ks;
    logic [SlotW-1:0] addr;
    logic [DataW-1:0] sp;
    logic [DataW-1:0] ks;
  } slot_wr_t;

endpackage

// ===== rtl/rrts_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_slot_table
// saved stack pointer and kernel stack top per slot, one write, one
// registered read per cycle
// ----------------------------------------------------------------------------
module rrts_slot_table (
  input  logic                         clk_i,
  input  rrts_pkg::slot_wr_t           wr_i,
  input  logic [rrts_pkg::SlotW-1:0]   rd_addr_i,
  output logic [rrts_pkg::DataW-1:0]   rd_sp_o,
  output logic [rrts_pkg::DataW-1:0]   rd_ks_o
);
  import rrts_pkg::*;

  logic [DataW-1:0] sp_mem [MaxTasks];
  logic [DataW-1:0] ks_mem [MaxTasks];
  logic [DataW-1:0] rd_sp_q;
  logic [DataW-1:0] rd_ks_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_sp) begin
      sp_mem[wr_i.addr] <= wr_i.sp;
    end
    if (wr_i.we_ks) begin
      ks_mem[wr_i.addr] <= wr_i.ks;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sp_q <= sp_mem[rd_addr_i];
    rd_ks_q <= ks_mem[rd_addr_i];
  end

  assign rd_sp_o = rd_sp_q;
  assign rd_ks_o = rd_ks_q;

endmodule

// ===== rtl/round_robin_task_switcher.sv =====
`timescale 1ns / 1ps
// create and exit: idle, then done, where the result beat is registered once the output is free
// switch: idle, walk, then done; the walk steps over 1 up to the task count slots, and the walk
//   unit tests one slot per cycle against the dead flags
// one item at a time: the next input beat is taken only back in idle, once the result beat is registered
// reset: kernel task in slot 0 running, one task; slot memories not cleared
// ----------------------------------------------------------------------------
// round_robin_task_switcher
// task slot table with create, round robin switch and exit commands
// ----------------------------------------------------------------------------
`include "round_robin_task_switcher_defines.svh"

module round_robin_task_switcher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrts_pkg::AddrW-1:0]   paddr,
  input  logic [rrts_pkg::DataW-1:0]   pwdata,
  output logic [rrts_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rrts_pkg::CmdW-1:0]    cmd_i,
  input  logic [rrts_pkg::DataW-1:0]   stack_pointer_in_i,
  input  logic [rrts_pkg::DataW-1:0]   new_kernel_stack_top_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rrts_pkg::DataW-1:0]   resume_stack_pointer_o,
  output logic [rrts_pkg::DataW-1:0]   resume_kernel_stack_top_o,
  output logic [rrts_pkg::IdW-1:0]     task_id_o,
  output logic [rrts_pkg::StatW-1:0]   status_o
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q;
  logic [DataW-1:0]  boot_stack_q;
  logic [MaxTasks-1:0] dead_q;
  logic [SlotW-1:0]  current_q;
  logic [CntW-1:0]   task_cnt_q;
  logic [CmdW-1:0]   cmd_q;
  logic [SlotW-1:0]  cand_q;
  logic [IdW-1:0]    res_id_q;
  logic [StatW-1:0]  res_st_q;
  logic              out_valid_q;
  logic [DataW-1:0]  out_sp_q;
  logic [DataW-1:0]  out_ks_q;
  logic [IdW-1:0]    out_id_q;
  logic [StatW-1:0]  out_st_q;

  logic              accept;
  logic              table_full;
  logic              out_free;
  logic [CntW-1:0]   cand_inc;
  logic [SlotW-1:0]  nx;
  logic              nx_live;
  logic [SlotW-1:0]  rd_addr;
  slot_wr_t          wr;
  logic [DataW-1:0]  rd_sp;
  logic [DataW-1:0]  rd_ks;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BOOT_STACK) ? boot_stack_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_stack_q <= '0;
    end else if (psel && penable && pwrite && (paddr == ADDR_BOOT_STACK)) begin
      boot_stack_q <= pwdata;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign table_full = (task_cnt_q == CntW'(MaxTasks));
  assign out_free   = !out_valid_q || !out_stall_i;

  // walk unit: next slot with wraparound, live unless dead
  always_comb begin
    cand_inc = CntW'(cand_q) + CntW'(1);
    nx       = (cand_inc >= task_cnt_q) ? '0 : cand_inc[SlotW-1:0];
    nx_live  = !dead_q[nx];
  end

  // hold the chosen slot on the read port while the result waits
  assign rd_addr = (state_q == ST_DONE) ? cand_q : nx;

  always_comb begin
    wr.we_sp = 1'b0;
    wr.we_ks = 1'b0;
    wr.addr  = current_q;
    wr.sp    = stack_pointer_in_i;
    wr.ks    = new_kernel_stack_top_i;
    if (accept) begin
      case (cmd_i)
        CMD_CREATE: begin
          if (!table_full) begin
            wr.we_sp = 1'b1;
            wr.we_ks = 1'b1;
            wr.addr  = task_cnt_q[SlotW-1:0];
          end
        end
        CMD_SWITCH: begin
          wr.we_sp = 1'b1;
        end
        default: ;
      endcase
    end
  end

  rrts_slot_table u_slot_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_sp_o   (rd_sp),
    .rd_ks_o   (rd_ks)
  );

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dead_q      <= '0;
      current_q   <= '0;
      task_cnt_q  <= CntW'(1);
      cmd_q       <= CMD_CREATE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            state_q <= (cmd_i == CMD_SWITCH) ? ST_WALK : ST_DONE;
            case (cmd_i)
              CMD_CREATE: begin
                if (!table_full) begin
                  task_cnt_q <= task_cnt_q + CntW'(1);
                end
              end
              CMD_EXIT: begin
                if (current_q != '0) begin
                  dead_q[current_q] <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (nx_live) begin
            current_q <= nx;
            state_q   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q <= current_q;
      case (cmd_i)
        CMD_CREATE: begin
          res_id_q <= table_full ? '0 : IdW'(task_cnt_q) + IdW'(1);
          res_st_q <= table_full ? STATUS_FULL : STATUS_OK;
        end
        CMD_EXIT: begin
          res_id_q <= '0;
          res_st_q <= (current_q == '0) ? STATUS_REFUSE : STATUS_OK;
        end
        default: begin
          res_id_q <= '0;
          res_st_q <= STATUS_OK;
        end
      endcase
    end else if (state_q == ST_WALK) begin
      cand_q <= nx;
    end
    if (state_q == ST_DONE && out_free) begin
      if (cmd_q == CMD_SWITCH) begin
        out_sp_q <= rd_sp;
        // slot 0 takes its kernel stack from the live register
        out_ks_q <= (cand_q == '0) ? boot_stack_q : rd_ks;
        out_id_q <= IdW'(cand_q) + IdW'(1);
        out_st_q <= STATUS_OK;
      end else begin
        out_sp_q <= '0;
        out_ks_q <= '0;
        out_id_q <= res_id_q;
        out_st_q <= res_st_q;
      end
    end
  end

  assign out_valid_o               = out_valid_q;
  assign resume_stack_pointer_o    = out_sp_q;
  assign resume_kernel_stack_top_o = out_ks_q;
  assign task_id_o                 = out_id_q;
  assign status_o                  = out_st_q;

  `RRTS_ASSERT(a_kernel_alive, !dead_q[0], "kernel slot marked dead")
  `RRTS_ASSERT(a_cur_in_table, CntW'(current_q) < task_cnt_q, "current slot beyond task count")
  `RRTS_ASSERT(a_done_emits, (state_q == ST_DONE) && out_free |=> out_valid_q, "result beat lost")
  `RRTS_ASSERT(a_walk_bound, (state_q == ST_WALK) |-> CntW'(cand_q) < task_cnt_q, "walk left table")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round robin task switcher testbench
// drives create, switch, exit and unused commands with random gaps on the command
// channel and random stalls on the result channel, tracks the task table on its own and checks every result beat in
// order against the expected resume data, id and status
// ----------------------------------------------------------------------------
module testbench;
  import rrts_pkg::*;

  localparam int                SETTLE     = 24;   // longest walk plus margin
  localparam int                IDLE_LIMIT = 3000; // cycles without any beat
  localparam int                HOLD_OFF   = 400;
  localparam int                PHASE_ITEMS = 240;
  localparam logic [CmdW-1:0]   CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SLOT_UNUSED  = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_DEAD    = 2'd3
  } slot_state_e;

  typedef struct packed {
    logic [DataW-1:0] sp;
    logic [DataW-1:0] ks;
    logic [IdW-1:0]   id;
    logic [StatW-1:0] status;
  } resume_t;

  class task_table_scoreboard;
    slot_state_e      slot_st [MaxTasks];
    logic [DataW-1:0] saved_sp [MaxTasks];
    logic [DataW-1:0] kstack [MaxTasks];
    int               cur_slot;
    int               task_cnt;
    logic [DataW-1:0] boot_stack;
    resume_t          pending_resumes[$];
    int               errors;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i]  = SLOT_UNUSED;
        saved_sp[i] = '0;
        kstack[i]   = '0;
      end
      slot_st[0] = SLOT_RUNNING;
      cur_slot   = 0;
      task_cnt   = 1;
      boot_stack = '0;
      errors     = 0;
    endfunction

    function int outstanding();
      return pending_resumes.size();
    endfunction

    task report(input string msg);
      $display("[%0t] ERROR %s", $time, msg);
      errors++;
    endtask

    // work out the result of one accepted command beat
    function void note_command(input logic [CmdW-1:0] c, input logic [DataW-1:0] sp,
                               input logic [DataW-1:0] ks);
      resume_t r;
      int      nxt;
      r = '0;
      case (c)
        CMD_CREATE: begin
          if (task_cnt >= MaxTasks) begin
            r.status = STATUS_FULL;
          end else begin
            slot_st[task_cnt]  = SLOT_READY;
            saved_sp[task_cnt] = sp;
            kstack[task_cnt]   = ks;
            task_cnt++;
            r.id = IdW'(task_cnt);
          end
        end
        CMD_SWITCH: begin
          saved_sp[cur_slot] = sp;
          // walk starts after the current slot whatever its state; slot 0 never dies
          nxt = cur_slot;
          do begin
            nxt++;
            if (nxt >= task_cnt) nxt = 0;
          end while (slot_st[nxt] == SLOT_DEAD);
          cur_slot     = nxt;
          slot_st[nxt] = SLOT_RUNNING;
          r.sp = saved_sp[nxt];
          r.ks = (nxt == 0) ? boot_stack : kstack[nxt];
          r.id = IdW'(nxt + 1);
        end
        CMD_EXIT: begin
          if (cur_slot == 0) r.status = STATUS_REFUSE;
          else slot_st[cur_slot] = SLOT_DEAD;
        end
        default: ;
      endcase
      pending_resumes.push_back(r);
    endfunction

    task check_result(input resume_t got);
      resume_t want;
      if (pending_resumes.size() == 0) begin
        report("result beat with no command pending");
      end else begin
        want = pending_resumes.pop_front();
        if (got.sp !== want.sp)
          report($sformatf("resume_stack_pointer %h, want %h", got.sp, want.sp));
        if (got.ks !== want.ks)
          report($sformatf("resume_kernel_stack_top %h, want %h", got.ks, want.ks));
        if (got.id !== want.id)
          report($sformatf("task_id %0d, want %0d", got.id, want.id));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i = '0;
  logic [DataW-1:0]    stack_pointer_in_i = '0;
  logic [DataW-1:0]    new_kernel_stack_top_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DataW-1:0]    resume_stack_pointer_o;
  logic [DataW-1:0]    resume_kernel_stack_top_o;
  logic [IdW-1:0]      task_id_o;
  logic [StatW-1:0]    status_o;

  task_table_scoreboard sb;
  int                   send_calm = 0;
  int                   recv_calm = 0;
  int                   idle_cycles = 0;
  bit                   hold_req = 1'b0;

  round_robin_task_switcher u_dut (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .psel                      (psel),
    .penable                   (penable),
    .pwrite                    (pwrite),
    .paddr                     (paddr),
    .pwdata                    (pwdata),
    .prdata                    (prdata),
    .pready                    (pready),
    .in_valid_i                (in_valid_i),
    .in_stall_o                (in_stall_o),
    .cmd_i                     (cmd_i),
    .stack_pointer_in_i        (stack_pointer_in_i),
    .new_kernel_stack_top_i    (new_kernel_stack_top_i),
    .out_valid_o               (out_valid_o),
    .out_stall_i               (out_stall_i),
    .resume_stack_pointer_o    (resume_stack_pointer_o),
    .resume_kernel_stack_top_o (resume_kernel_stack_top_o),
    .task_id_o                 (task_id_o),
    .status_o                  (status_o)
  );

  always #5 clk_i = ~clk_i;

  // mostly random gaps, now and then a run of back-to-back beats
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [CmdW-1:0] c, input logic [DataW-1:0] sp,
                           input logic [DataW-1:0] ks);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    cmd_i                  <= c;
    stack_pointer_in_i     <= sp;
    new_kernel_stack_top_i <= ks;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    int              roll;
    logic [CmdW-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 6) c = CMD_CREATE;
    else if (roll < 94) c = CMD_SWITCH;
    else if (roll < 97) c = CMD_EXIT;
    else c = CMD_UNUSED;
    send_item(c, pick_word(), pick_word());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_boot_stack(input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BOOT_STACK;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.boot_stack = value;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== value)
      sb.report($sformatf("boot_stack_top read %h, want %h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = pick_gap(recv_calm);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_OFF;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_command(cmd_i, stack_pointer_in_i, new_kernel_stack_top_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({resume_stack_pointer_o, resume_kernel_stack_top_o,
                         task_id_o, status_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[%0t] ERROR no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [DataW-1:0] boot_values [6];
    sb = new();
    boot_values = '{32'h0000_0000, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0000_0001,
                    32'h0};
    boot_values[2] = $urandom();
    boot_values[5] = $urandom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_boot_stack(32'hffff_ffff);

    // directed: kernel exit refused, lone kernel switch, unused code
    send_item(CMD_EXIT, 32'h0, 32'h0);
    send_item(CMD_SWITCH, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_CREATE, 32'h0, 32'hffff_ffff);
    send_item(CMD_CREATE, 32'hffff_ffff, 32'h0);
    send_item(CMD_SWITCH, 32'h0, 32'h0);
    // exit, then exit of the same dead task, then switch away from it
    send_item(CMD_EXIT, 32'h0, 32'h0);
    send_item(CMD_EXIT, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_SWITCH, 32'h1234_5678, 32'h0);
    send_item(CMD_SWITCH, 32'h8765_4321, 32'h0);
    send_item(CMD_SWITCH, 32'hffff_ffff, 32'h0);
    // fill the table, then one create too many
    repeat (MaxTasks - 3) send_item(CMD_CREATE, pick_word(), pick_word());
    send_item(CMD_CREATE, 32'hffff_ffff, 32'hffff_ffff);

    foreach (boot_values[p]) begin
      drain();
      write_boot_stack(boot_values[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 100) hold_req = 1'b1;
        send_random();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
